// ===== design/graph_threshold_segmentation_core_macros.svh =====
// Assertion macros used by the top-level core design file.
`ifndef GRAPH_THRESHOLD_SEGMENTATION_CORE_MACROS_SVH
`define GRAPH_THRESHOLD_SEGMENTATION_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gts_pkg.sv =====
package gts_pkg;

    localparam int THR_BITS     = 24;
    localparam int NCNT_BITS    = 7;
    localparam int DIV_CNT_BITS = 5;

    localparam logic [THR_BITS-1:0]  THR_MAX    = 24'hFFFFFF;
    localparam logic [THR_BITS-1:0]  THR_RESET  = 24'd65536;
    localparam logic [NCNT_BITS-1:0] NCNT_RESET = 7'd64;

    typedef enum logic [0:0] {
        CFG_THRESHOLD  = 1'b0,
        CFG_NODE_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== design/gts_fifo.sv =====
module gts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

endmodule

// ===== design/gts_front.sv =====
module gts_front #(
    parameter int MAX_EDGES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_last,
    output logic o_full,
    output logic o_q_push,
    input  logic i_q_full,
    output logic o_keep,
    output logic o_ovf
);

    localparam int FW = $clog2(MAX_EDGES + 1);

    logic [FW-1:0] r_fill;
    logic          r_ovf;
    logic          acc;

    assign o_full   = i_q_full;
    assign acc      = i_push && !i_q_full;
    assign o_q_push = acc;
    assign o_keep   = (r_fill < FW'(MAX_EDGES));
    assign o_ovf    = r_ovf || !o_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
        end else if (acc) begin
            if (i_last) begin
                r_fill <= '0;
                r_ovf  <= 1'b0;
            end else begin
                r_fill <= r_fill + FW'(o_keep);
                r_ovf  <= o_ovf;
            end
        end
    end

endmodule

// ===== design/gts_div.sv =====
module gts_div #(
    parameter int DVW = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gts_pkg::THR_BITS-1:0] i_dividend,
    input  logic [DVW-1:0]               i_divisor,
    output logic [gts_pkg::THR_BITS-1:0] o_quo,
    output gts_pkg::t_div_stat           o_stat
);

    localparam int QW = gts_pkg::THR_BITS;
    localparam int CB = gts_pkg::DIV_CNT_BITS;

    logic [QW-1:0]  r_quo;
    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_dvs;
    logic [CB-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DVW:0]   trial;
    logic           ge;

    assign trial  = {r_rem, r_quo[QW-1]};
    assign ge     = (trial >= {1'b0, r_dvs});
    assign o_quo  = r_quo;
    assign o_stat = '{busy: r_busy, done: r_done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[QW-2:0], ge};
                r_rem <= ge ? DVW'(trial - {1'b0, r_dvs}) : trial[DVW-1:0];
                r_cnt <= r_cnt + CB'(1);
                if (r_cnt == CB'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== design/gts_back.sv =====
module gts_back #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [gts_pkg::THR_BITS-1:0]  i_thr_k,
    input  logic [gts_pkg::NCNT_BITS-1:0] i_node_count,
    input  logic                          i_cmd_empty,
    output logic                          o_cmd_pop,
    input  logic [$clog2(MAX_NODES)-1:0]  i_cmd_a,
    input  logic [$clog2(MAX_NODES)-1:0]  i_cmd_b,
    input  logic [WEIGHT_BITS-1:0]        i_cmd_w,
    input  logic                          i_cmd_keep,
    input  logic                          i_cmd_last,
    input  logic                          i_cmd_ovf,
    input  logic                          i_res_full,
    output logic                          o_res_push,
    output logic [$clog2(MAX_NODES)-1:0]  o_res_index,
    output logic [$clog2(MAX_NODES)-1:0]  o_res_label,
    output logic [$clog2(MAX_NODES):0]    o_res_count,
    output logic                          o_res_ovf,
    output logic                          o_res_last
);

    localparam int NB  = $clog2(MAX_NODES);
    localparam int EB  = $clog2(MAX_EDGES);
    localparam int FW  = EB + 1;
    localparam int CW  = EB + 2;
    localparam int SZW = NB + 1;
    localparam int TB  = gts_pkg::THR_BITS;
    localparam int SW  = ((WEIGHT_BITS > TB) ? WEIGHT_BITS : TB) + 1;
    localparam int NW  = ((NB + 1) > gts_pkg::NCNT_BITS) ? (NB + 1) : gts_pkg::NCNT_BITS;
    localparam int EW  = 2 * NB + WEIGHT_BITS;

    typedef enum logic [3:0] {
        S_LOAD, S_CUT, S_PAIR, S_MERGE, S_INIT, S_EFIND, S_ROOT,
        S_TEST, S_DIV, S_SWEEP, S_CNT, S_EMRD, S_EMWR
    } t_state;

    logic [EW-1:0]  r_bank0 [MAX_EDGES];
    logic [EW-1:0]  r_bank1 [MAX_EDGES];
    logic [NB-1:0]  r_root  [MAX_NODES];
    logic [SZW-1:0] r_size  [MAX_NODES];
    logic [TB-1:0]  r_thr   [MAX_NODES];

    t_state         r_state, n_state;
    logic [FW-1:0]  r_fill, n_fill;
    logic           r_ovf, n_ovf;
    logic           r_src, n_src;
    logic [CW-1:0]  r_w, n_w;
    logic [CW-1:0]  r_base, n_base;
    logic [CW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_j, n_j;
    logic [CW-1:0]  r_k, n_k;
    logic [CW-1:0]  r_iend, n_iend;
    logic [CW-1:0]  r_jend, n_jend;
    logic [NB-1:0]  r_sw, n_sw;
    logic [NB-1:0]  r_swd, n_swd;
    logic           r_swv, n_swv;
    logic [WEIGHT_BITS-1:0] r_ew, n_ew;
    logic [NB-1:0]  r_ra, n_ra;
    logic [NB-1:0]  r_rb, n_rb;
    logic [NB-1:0]  r_lo, n_lo;
    logic [NB-1:0]  r_hi, n_hi;
    logic [NB:0]    r_ncomp, n_ncomp;
    logic [NB:0]    r_nlim, n_nlim;

    logic [EW-1:0]  r_d0a, r_d0b, r_d1a, r_d1b;
    logic [NB-1:0]  r_rqa, r_rqb;
    logic [SZW-1:0] r_sza, r_szb;
    logic [TB-1:0]  r_tha, r_thb;

    logic           b0_we, b1_we;
    logic [EB-1:0]  b0_wa, b1_wa;
    logic [EW-1:0]  b0_wd, b1_wd;
    logic [NB-1:0]  rt_ra, rt_rb;
    logic           rt_we;
    logic [NB-1:0]  rt_wa, rt_wd;
    logic           sz_we;
    logic [NB-1:0]  sz_wa;
    logic [SZW-1:0] sz_wd;
    logic           th_we;
    logic [NB-1:0]  th_wa;
    logic [TB-1:0]  th_wd;

    logic [CW-1:0]  nf;
    logic [EW-1:0]  da, db;
    logic           take_a;
    logic [CW-1:0]  t1, t2, nb;
    logic [SZW:0]   szsum;
    logic [SZW-1:0] nsz;
    logic [SW-1:0]  thsum;
    logic [NB-1:0]  nlast;
    logic [NW-1:0]  ncl;
    logic           go_next, go_cnt;
    logic           div_start;
    logic [TB-1:0]  div_q;
    gts_pkg::t_div_stat div_stat;

    gts_div #(.DVW(SZW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_thr_k),
        .i_divisor  (nsz),
        .o_quo      (div_q),
        .o_stat     (div_stat)
    );

    assign nf    = CW'(r_fill);
    assign da    = r_src ? r_d1a : r_d0a;
    assign db    = r_src ? r_d1b : r_d0b;
    assign nlast = NB'(r_nlim - (NB + 1)'(1));
    assign ncl   = NW'(i_node_count);
    assign szsum = (SZW + 1)'(r_sza) + (SZW + 1)'(r_szb);
    assign nsz   = (szsum > (SZW + 1)'(MAX_NODES)) ? SZW'(MAX_NODES) : szsum[SZW-1:0];
    assign thsum = SW'(r_ew) + SW'(div_q);

    assign o_res_index = r_sw;
    assign o_res_label = r_rqa;
    assign o_res_count = r_ncomp;
    assign o_res_ovf   = r_ovf;
    assign o_res_last  = (r_sw == nlast);

    always_comb begin
        n_state = r_state;  n_fill = r_fill;   n_ovf  = r_ovf;   n_src = r_src;
        n_w     = r_w;      n_base = r_base;   n_i    = r_i;     n_j   = r_j;
        n_k     = r_k;      n_iend = r_iend;   n_jend = r_jend;  n_sw  = r_sw;
        n_swd   = r_swd;    n_swv  = r_swv;    n_ew   = r_ew;    n_ra  = r_ra;
        n_rb    = r_rb;     n_lo   = r_lo;     n_hi   = r_hi;    n_ncomp = r_ncomp;
        n_nlim  = r_nlim;
        o_cmd_pop = 1'b0;  o_res_push = 1'b0;  div_start = 1'b0;
        b0_we = 1'b0;  b0_wa = r_fill[EB-1:0];  b0_wd = {i_cmd_a, i_cmd_b, i_cmd_w};
        b1_we = 1'b0;  b1_wa = r_k[EB-1:0];
        take_a = (r_i < r_iend) && ((r_j >= r_jend) ||
                 (da[WEIGHT_BITS-1:0] <= db[WEIGHT_BITS-1:0]));
        b1_wd = take_a ? da : db;
        rt_ra = r_sw;  rt_rb = r_sw;
        rt_we = 1'b0;  rt_wa = r_swd;  rt_wd = r_lo;
        sz_we = 1'b0;  sz_wa = r_sw;   sz_wd = SZW'(1);
        th_we = 1'b0;  th_wa = r_sw;   th_wd = i_thr_k;
        t1 = r_base + r_w;
        t2 = r_base + (r_w << 1);
        nb = r_base + (r_w << 1);
        go_next = 1'b0;  go_cnt = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd_keep) begin
                        b0_we  = 1'b1;
                        n_fill = r_fill + FW'(1);
                    end
                    if (i_cmd_last) begin
                        n_ovf   = i_cmd_ovf;
                        n_state = S_CUT;
                        if (ncl == '0) begin
                            n_nlim = (NB + 1)'(1);
                        end else if (ncl > NW'(MAX_NODES)) begin
                            n_nlim = (NB + 1)'(MAX_NODES);
                        end else begin
                            n_nlim = (NB + 1)'(ncl);
                        end
                    end
                end
            end
            S_CUT: begin
                n_src = 1'b0;
                n_sw  = '0;
                if (nf <= CW'(1)) begin
                    n_state = S_INIT;
                end else begin
                    n_w     = CW'(1);
                    n_base  = '0;
                    n_state = S_PAIR;
                end
            end
            S_PAIR: begin
                n_i     = r_base;
                n_k     = r_base;
                n_iend  = (t1 < nf) ? t1 : nf;
                n_j     = n_iend;
                n_jend  = (t2 < nf) ? t2 : nf;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (r_src) begin
                    b0_we = 1'b1;
                    b0_wa = r_k[EB-1:0];
                    b0_wd = b1_wd;
                end else begin
                    b1_we = 1'b1;
                end
                if (take_a) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
                n_k = r_k + CW'(1);
                if (r_k + CW'(1) == r_jend) begin
                    n_state = S_PAIR;
                    if (nb >= nf) begin
                        n_src  = ~r_src;
                        n_w    = r_w << 1;
                        n_base = '0;
                        if ((r_w << 1) >= nf) begin
                            n_sw    = '0;
                            n_state = S_INIT;
                        end
                    end else begin
                        n_base = nb;
                    end
                end
            end
            S_INIT: begin
                rt_we = 1'b1;  rt_wa = r_sw;  rt_wd = r_sw;
                sz_we = 1'b1;
                th_we = 1'b1;
                if (r_sw == NB'(MAX_NODES - 1)) begin
                    n_i = '0;
                    if (nf == '0) begin
                        go_cnt = 1'b1;
                    end else begin
                        n_state = S_EFIND;
                    end
                end else begin
                    n_sw = r_sw + NB'(1);
                end
            end
            S_EFIND: begin
                n_ew    = da[WEIGHT_BITS-1:0];
                rt_ra   = da[EW-1 -: NB];
                rt_rb   = da[WEIGHT_BITS +: NB];
                n_state = S_ROOT;
            end
            S_ROOT: begin
                n_ra = r_rqa;
                n_rb = r_rqb;
                if (r_rqa == r_rqb) begin
                    go_next = 1'b1;
                end else begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if ((SW'(r_ew) > SW'(r_tha)) || (SW'(r_ew) > SW'(r_thb))) begin
                    go_next = 1'b1;
                end else begin
                    n_lo      = (r_ra < r_rb) ? r_ra : r_rb;
                    n_hi      = (r_ra < r_rb) ? r_rb : r_ra;
                    sz_we     = 1'b1;
                    sz_wa     = n_lo;
                    sz_wd     = nsz;
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    th_we   = 1'b1;
                    th_wa   = r_lo;
                    th_wd   = (thsum > SW'(gts_pkg::THR_MAX)) ? gts_pkg::THR_MAX
                                                             : thsum[TB-1:0];
                    n_sw    = '0;
                    n_swv   = 1'b0;
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                n_swd = r_sw;
                n_swv = 1'b1;
                if (r_sw != NB'(MAX_NODES - 1)) begin
                    n_sw = r_sw + NB'(1);
                end
                if (r_swv && (r_rqa == r_hi)) begin
                    rt_we = 1'b1;
                end
                if (r_swv && (r_swd == NB'(MAX_NODES - 1))) begin
                    go_next = 1'b1;
                end
            end
            S_CNT: begin
                n_swd = r_sw;
                n_swv = 1'b1;
                if (r_sw != nlast) begin
                    n_sw = r_sw + NB'(1);
                end
                if (r_swv && (r_rqa == r_swd)) begin
                    n_ncomp = r_ncomp + (NB + 1)'(1);
                end
                if (r_swv && (r_swd == nlast)) begin
                    n_sw    = '0;
                    n_state = S_EMRD;
                end
            end
            S_EMRD: begin
                n_state = S_EMWR;
            end
            S_EMWR: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_sw == nlast) begin
                        n_fill  = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_sw    = r_sw + NB'(1);
                        n_state = S_EMRD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        if (go_next) begin
            n_i = r_i + CW'(1);
            if (r_i + CW'(1) == nf) begin
                go_cnt = 1'b1;
            end else begin
                n_state = S_EFIND;
            end
        end
        if (go_cnt) begin
            n_sw    = '0;
            n_swv   = 1'b0;
            n_ncomp = '0;
            n_state = S_CNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b0_we) begin
            r_bank0[b0_wa] <= b0_wd;
        end
        if (b1_we) begin
            r_bank1[b1_wa] <= b1_wd;
        end
        r_d0a <= r_bank0[n_i[EB-1:0]];
        r_d0b <= r_bank0[n_j[EB-1:0]];
        r_d1a <= r_bank1[n_i[EB-1:0]];
        r_d1b <= r_bank1[n_j[EB-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (rt_we) begin
            r_root[rt_wa] <= rt_wd;
        end
        if (sz_we) begin
            r_size[sz_wa] <= sz_wd;
        end
        if (th_we) begin
            r_thr[th_wa] <= th_wd;
        end
        r_rqa <= r_root[rt_ra];
        r_rqb <= r_root[rt_rb];
        r_sza <= r_size[r_rqa];
        r_szb <= r_size[r_rqb];
        r_tha <= r_thr[r_rqa];
        r_thb <= r_thr[r_rqb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_swv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
            r_swv   <= n_swv;
        end
        r_src   <= n_src;   r_w    <= n_w;     r_base <= n_base;
        r_i     <= n_i;     r_j    <= n_j;     r_k    <= n_k;
        r_iend  <= n_iend;  r_jend <= n_jend;  r_sw   <= n_sw;
        r_swd   <= n_swd;   r_ew   <= n_ew;    r_ra   <= n_ra;
        r_rb    <= n_rb;    r_lo   <= n_lo;    r_hi   <= n_hi;
        r_ncomp <= n_ncomp; r_nlim <= n_nlim;
    end

endmodule

// ===== design/graph_threshold_segmentation_core.sv =====
// Threshold graph segmentation. Edges (node_a, node_b, Q0.16 weight) enter one per cycle
// while full is low, through a short request queue, and are stored, up to MAX_EDGES; extra
// edges are dropped and flagged in edge_overflow. The edge with last_edge set starts the
// cut, after which one result per node 0 .. n-1 comes out, n being node_count clamped to
// 1 .. MAX_NODES: its label (smallest node of its component), the component count and the
// overflow flag. A cut merge-sorts the stored edges between its ping-pong edge memories, resets the
// union-find store, then looks up the roots of each edge; each merge waits on the bit-serial
// k/size divider and runs a relabel sweep; then the components are counted and the results
// emitted. Edges of the next cut are queued meanwhile until the request queue fills.
`include "graph_threshold_segmentation_core_macros.svh"

module graph_threshold_segmentation_core #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [gts_pkg::THR_BITS-1:0]  i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [$clog2(MAX_NODES)-1:0]  i_node_a,
    input  logic [$clog2(MAX_NODES)-1:0]  i_node_b,
    input  logic [WEIGHT_BITS-1:0]        i_weight,
    input  logic                          i_last_edge,
    output logic                          empty,
    input  logic                          pop,
    output logic [$clog2(MAX_NODES)-1:0]  o_node_index,
    output logic [$clog2(MAX_NODES)-1:0]  o_component_label,
    output logic [$clog2(MAX_NODES):0]    o_component_count,
    output logic                          o_edge_overflow,
    output logic                          o_last_node
);

    localparam int NB   = $clog2(MAX_NODES);
    localparam int CMDW = 2 * NB + WEIGHT_BITS + 3;
    localparam int RESW = 3 * NB + 3;
    localparam int QD   = 4;

    logic [gts_pkg::THR_BITS-1:0]  r_thr_k;
    logic [gts_pkg::NCNT_BITS-1:0] r_node_count;

    logic            q_push, q_full, keep, ovf;
    logic            cmd_empty, cmd_pop;
    logic [CMDW-1:0] cmd_data;
    logic            res_push, res_full;
    logic [NB-1:0]   res_index, res_label;
    logic [NB:0]     res_count;
    logic            res_ovf, res_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_k      <= gts_pkg::THR_RESET;
            r_node_count <= gts_pkg::NCNT_RESET;
        end else if (i_cfg_we) begin
            unique case (gts_pkg::t_cfg_idx'(i_cfg_idx))
                gts_pkg::CFG_THRESHOLD:  r_thr_k      <= i_cfg_data;
                gts_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data[gts_pkg::NCNT_BITS-1:0];
            endcase
        end
    end

    gts_front #(.MAX_EDGES(MAX_EDGES)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_last   (i_last_edge),
        .o_full   (full),
        .o_q_push (q_push),
        .i_q_full (q_full),
        .o_keep   (keep),
        .o_ovf    (ovf)
    );

    gts_fifo #(.WIDTH(CMDW), .DEPTH(QD)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({i_node_a, i_node_b, i_weight, keep, i_last_edge, ovf}),
        .o_full  (q_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_data),
        .o_empty (cmd_empty)
    );

    gts_back #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_thr_k      (r_thr_k),
        .i_node_count (r_node_count),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .i_cmd_a      (cmd_data[CMDW-1 -: NB]),
        .i_cmd_b      (cmd_data[CMDW-1-NB -: NB]),
        .i_cmd_w      (cmd_data[3 +: WEIGHT_BITS]),
        .i_cmd_keep   (cmd_data[2]),
        .i_cmd_last   (cmd_data[1]),
        .i_cmd_ovf    (cmd_data[0]),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res_index  (res_index),
        .o_res_label  (res_label),
        .o_res_count  (res_count),
        .o_res_ovf    (res_ovf),
        .o_res_last   (res_last)
    );

    gts_fifo #(.WIDTH(RESW), .DEPTH(QD)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_index, res_label, res_count, res_ovf, res_last}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  ({o_node_index, o_component_label, o_component_count,
                   o_edge_overflow, o_last_node}),
        .o_empty (empty)
    );

    `GTS_ASSERT_IMP(a_label_min, i_clk, i_rst_n, !empty, o_component_label <= o_node_index, "label above node index")
    `GTS_ASSERT_IMP(a_count_nz, i_clk, i_rst_n, !empty && o_last_node, o_component_count != '0, "zero component count")
    `GTS_ASSERT_NXT(a_index_seq, i_clk, i_rst_n, pop && !empty && !o_last_node, empty || (o_node_index == NB'($past(o_node_index) + 1'b1)), "node index out of sequence")

endmodule

// ===== sim/graph_threshold_segmentation_core_checker.sv =====
`timescale 1ns / 100ps

module graph_threshold_segmentation_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [5:0]  i_node_a,
    input  logic [5:0]  i_node_b,
    input  logic [15:0] i_weight,
    input  logic        i_last_edge,
    input  logic        empty,
    input  logic        pop,
    input  logic [5:0]  i_node_index,
    input  logic [5:0]  i_component_label,
    input  logic [6:0]  i_component_count,
    input  logic        i_edge_overflow,
    input  logic        i_last_node,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [5:0] node;
        logic [5:0] label;
        logic [6:0] count;
        logic       ovf;
        logic       last;
    } t_label;

    t_label     label_q[$];
    logic [23:0] k_const;
    logic [6:0]  node_cnt;
    logic [5:0]  edge_a[256], edge_b[256], sort_a[256], sort_b[256];
    logic [15:0] edge_w[256], sort_w[256];
    int          fill;
    logic        ovf_seen;
    logic [5:0]  parent[64];
    logic [6:0]  size_of[64];
    logic [23:0] thr[64];

    int          i, j, n, roots;
    logic [5:0]  ra, rb, lo, hi, ta, tb;
    logic [15:0] tw;
    logic [24:0] sum;
    t_label      got, want;

    function automatic logic [5:0] root_of(logic [5:0] x);
        while (parent[x] != x) x = parent[x];
        return x;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            k_const = gts_pkg::THR_RESET;
            node_cnt = gts_pkg::NCNT_RESET;
            fill = 0;
            ovf_seen = 1'b0;
            label_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == gts_pkg::CFG_THRESHOLD) k_const = i_cfg_data;
                else node_cnt = i_cfg_data[6:0];
            end
            if (pop && !empty) begin
                got = '{i_node_index, i_component_label, i_component_count,
                        i_edge_overflow, i_last_node};
                if (label_q.size() == 0) begin
                    $display("%0t: unexpected result node=%0d label=%0d", $time,
                             got.node, got.label);
                    o_fail_count++;
                end else begin
                    want = label_q.pop_front();
                    if (got.node !== want.node || got.label !== want.label ||
                        got.count !== want.count || got.ovf !== want.ovf ||
                        got.last !== want.last) begin
                        $display("%0t: mismatch exp node=%0d label=%0d count=%0d ovf=%0d last=%0d",
                                 $time, want.node, want.label, want.count, want.ovf, want.last);
                        $display("%0t:          got node=%0d label=%0d count=%0d ovf=%0d last=%0d",
                                 $time, got.node, got.label, got.count, got.ovf, got.last);
                        o_fail_count++;
                    end
                end
            end
            if (push && !full) begin
                if (fill < 256) begin
                    edge_a[fill] = i_node_a;
                    edge_b[fill] = i_node_b;
                    edge_w[fill] = i_weight;
                    fill++;
                end else begin
                    ovf_seen = 1'b1;
                end
                if (i_last_edge) begin
                    for (i = 0; i < 64; i++) begin
                        parent[i] = 6'(i);
                        size_of[i] = 7'd1;
                        thr[i] = k_const;
                    end
                    // stable insertion sort by weight
                    for (i = 0; i < fill; i++) begin
                        ta = edge_a[i];
                        tb = edge_b[i];
                        tw = edge_w[i];
                        j = i;
                        while (j > 0 && sort_w[j-1] > tw) begin
                            sort_a[j] = sort_a[j-1];
                            sort_b[j] = sort_b[j-1];
                            sort_w[j] = sort_w[j-1];
                            j--;
                        end
                        sort_a[j] = ta;
                        sort_b[j] = tb;
                        sort_w[j] = tw;
                    end
                    for (i = 0; i < fill; i++) begin
                        ra = root_of(sort_a[i]);
                        rb = root_of(sort_b[i]);
                        if (ra != rb && sort_w[i] <= thr[ra] && sort_w[i] <= thr[rb]) begin
                            lo = (ra < rb) ? ra : rb;
                            hi = (ra < rb) ? rb : ra;
                            parent[hi] = lo;
                            size_of[lo] = size_of[lo] + size_of[hi];
                            if (size_of[lo] > 64) size_of[lo] = 7'd64;
                            sum = sort_w[i] + k_const / size_of[lo];
                            thr[lo] = (sum > gts_pkg::THR_MAX) ? gts_pkg::THR_MAX : sum[23:0];
                        end
                    end
                    n = node_cnt;
                    if (n < 1) n = 1;
                    if (n > 64) n = 64;
                    roots = 0;
                    for (i = 0; i < n; i++)
                        if (root_of(6'(i)) == 6'(i)) roots++;
                    for (i = 0; i < n; i++)
                        label_q.push_back('{6'(i), root_of(6'(i)), 7'(roots), ovf_seen,
                                            (i + 1 == n)});
                    fill = 0;
                    ovf_seen = 1'b0;
                end
            end
        end
        o_pending = label_q.size();
    end

endmodule

// ===== sim/graph_threshold_segmentation_core_tb.sv =====
`timescale 1ns / 100ps

module graph_threshold_segmentation_core_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [23:0] i_cfg_data;
    logic        push;
    logic        full;
    logic [5:0]  i_node_a;
    logic [5:0]  i_node_b;
    logic [15:0] i_weight;
    logic        i_last_edge;
    logic        empty;
    logic        pop;
    logic [5:0]  o_node_index;
    logic [5:0]  o_component_label;
    logic [6:0]  o_component_count;
    logic        o_edge_overflow;
    logic        o_last_node;

    int fail_count, pending;
    int edges_sent;
    int active_nodes;
    bit quiet;
    bit hold_rx;

    graph_threshold_segmentation_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_node_a(i_node_a), .i_node_b(i_node_b), .i_weight(i_weight),
        .i_last_edge(i_last_edge),
        .empty(empty), .pop(pop),
        .o_node_index(o_node_index), .o_component_label(o_component_label),
        .o_component_count(o_component_count), .o_edge_overflow(o_edge_overflow),
        .o_last_node(o_last_node)
    );

    graph_threshold_segmentation_core_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_node_a(i_node_a), .i_node_b(i_node_b), .i_weight(i_weight),
        .i_last_edge(i_last_edge),
        .empty(empty), .pop(pop),
        .i_node_index(o_node_index), .i_component_label(o_component_label),
        .i_component_count(o_component_count), .i_edge_overflow(o_edge_overflow),
        .i_last_node(o_last_node),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 6000000);
        $display("TB_ERROR");
        $finish;
    end

    // result side
    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                pop <= 1'b0;
                repeat (800) @(negedge i_clk);
                hold_rx = 1'b0;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_edge(input logic [5:0] a, input logic [5:0] b,
                             input logic [15:0] w, input logic last);
        if (!quiet && $urandom_range(0, 6) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        push <= 1'b1;
        i_node_a <= a;
        i_node_b <= b;
        i_weight <= w;
        i_last_edge <= last;
        while (full) @(negedge i_clk);
        @(negedge i_clk);
        edges_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        wait (pending == 0);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_reg(input gts_pkg::t_cfg_idx idx, input logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == gts_pkg::CFG_NODE_COUNT) begin
            active_nodes = data[6:0];
            if (active_nodes < 1) active_nodes = 1;
            if (active_nodes > 64) active_nodes = 64;
        end
    endtask

    task automatic random_cut(input int n_edges);
        logic [5:0]  a, b;
        logic [15:0] w;
        for (int e = 0; e < n_edges; e++) begin
            if ($urandom_range(0, 9) == 0) begin
                a = 6'($urandom_range(0, 63));
                b = 6'($urandom_range(0, 63));
            end else begin
                a = 6'($urandom_range(0, active_nodes - 1));
                b = 6'($urandom_range(0, active_nodes - 1));
            end
            w = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 2) != 0) w = w >> $urandom_range(0, 15);
            send_edge(a, b, w, e == n_edges - 1);
        end
    endtask

    initial begin
        logic [23:0] k;
        logic [6:0]  nc;
        int phase;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = gts_pkg::CFG_THRESHOLD;
        i_cfg_data = '0;
        push = 1'b0;
        i_node_a = '0;
        i_node_b = '0;
        i_weight = '0;
        i_last_edge = 1'b0;
        quiet = 1'b0;
        hold_rx = 1'b0;
        edges_sent = 0;
        active_nodes = 64;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // defaults: self loop, weight extremes, far nodes
        send_edge(6'd0, 6'd63, 16'h0000, 1'b0);
        send_edge(6'd63, 6'd63, 16'hFFFF, 1'b0);
        send_edge(6'd5, 6'd6, 16'hFFFF, 1'b0);
        send_edge(6'd1, 6'd2, 16'h8000, 1'b1);
        drain();
        write_reg(gts_pkg::CFG_THRESHOLD, 24'd0);
        write_reg(gts_pkg::CFG_NODE_COUNT, 24'd0);
        send_edge(6'd0, 6'd1, 16'h0000, 1'b0);
        send_edge(6'd1, 6'd2, 16'h0001, 1'b1);
        drain();
        write_reg(gts_pkg::CFG_THRESHOLD, gts_pkg::THR_MAX);
        write_reg(gts_pkg::CFG_NODE_COUNT, 24'd127);
        send_edge(6'd10, 6'd20, 16'hFFFF, 1'b0);
        send_edge(6'd20, 6'd10, 16'h0000, 1'b0);
        send_edge(6'd62, 6'd63, 16'h1234, 1'b0);
        send_edge(6'd0, 6'd62, 16'hAAAA, 1'b0);
        send_edge(6'd42, 6'd21, 16'h5555, 1'b1);
        drain();
        write_reg(gts_pkg::CFG_THRESHOLD, 24'd1);
        write_reg(gts_pkg::CFG_NODE_COUNT, 24'd1);
        send_edge(6'd3, 6'd3, 16'h0007, 1'b1);
        drain();

        phase = 0;
        while (edges_sent < 470) begin
            case ($urandom_range(0, 4))
                0: k = 24'd0;
                1: k = gts_pkg::THR_MAX;
                2: k = gts_pkg::THR_RESET;
                3: k = 24'($urandom_range(0, 24'hFFFFFF));
                default: k = 24'($urandom_range(0, 24'h3FFFF));
            endcase
            case ($urandom_range(0, 5))
                0: nc = 7'd64;
                1: nc = 7'd1;
                2: nc = ($urandom_range(0, 1) != 0) ? 7'd0 : 7'd127;
                default: nc = 7'($urandom_range(1, 64));
            endcase
            if (phase == 2) nc = 7'd64;
            if (edges_sent > 400) quiet = 1'b1;
            write_reg(gts_pkg::CFG_THRESHOLD, k);
            write_reg(gts_pkg::CFG_NODE_COUNT, {17'd0, nc});
            if (phase == 1) begin
                random_cut(262);
            end else begin
                repeat ($urandom_range(2, 4)) begin
                    if (phase == 2) hold_rx = 1'b1;
                    random_cut($urandom_range(1, 20));
                    if (phase == 3) begin
                        push <= 1'b0;
                        wait (pending == 0);
                        @(negedge i_clk);
                    end
                end
            end
            drain();
            phase++;
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/gts_pkg.sv
design/gts_fifo.sv
design/gts_front.sv
design/gts_div.sv
design/gts_back.sv
design/graph_threshold_segmentation_core.sv
sim/graph_threshold_segmentation_core_checker.sv
sim/graph_threshold_segmentation_core_tb.sv
